FILE: hdl/ecg_heart_rate_estimator_core_macros.svh
// Assertion macros for the ECG heart rate estimator.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef ECG_HEART_RATE_ESTIMATOR_CORE_MACROS_SVH
`define ECG_HEART_RATE_ESTIMATOR_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ECGHR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define ECGHR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define ECGHR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ecghr_pkg.sv
// Shared constants and types for the ECG heart rate estimator.
// No dependencies; imported by every module of the block.
package ecghr_pkg;

    // Smoothing window geometry.
    localparam int WINDOW_TAPS = 5;
    localparam int HALF_SPAN   = (WINDOW_TAPS - 1) / 2;
    localparam int MEAN_LEN    = 2 * HALF_SPAN + 1;
    localparam int MEAN_START  = WINDOW_TAPS - MEAN_LEN;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int AMP_W   = 16;
    localparam int COUNT_W = 16;
    localparam int RATE_W  = 16;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 64;

    // Index and counter widths.
    localparam int IDX_W      = $clog2(WINDOW_TAPS);
    localparam int SEEN_W     = $clog2(WINDOW_TAPS + 1);
    localparam int PUSH_CNT_W = 2;

    // Window mean: the sum is biased to be non-negative, then multiplied by
    // a rounded-up reciprocal of the window length and shifted down.
    localparam int SUM_W       = AMP_W + $clog2(MEAN_LEN);
    localparam int MEAN_OFFSET = MEAN_LEN * (2 ** (AMP_W - 1));
    localparam int RECIP_SHIFT = SUM_W + $clog2(MEAN_LEN);
    localparam int RECIP_W     = RECIP_SHIFT + 1 - $clog2(MEAN_LEN);
    localparam int RECIP_MUL   = (2 ** RECIP_SHIFT + MEAN_LEN - 1) / MEAN_LEN;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Heart rate scaling: milliseconds per minute.
    localparam int SCALED_W = 32;
    localparam logic [15:0] BPM_SCALE = 16'd60000;
    localparam logic [RATE_W-1:0]  RATE_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Serial divider.
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Peak threshold after reset, 0.30 in Q3.12.
    localparam logic signed [AMP_W-1:0] PEAK_THRESH_RESET = 16'sd1229;

    // Control of the window mean unit.
    typedef struct packed {
        logic clr;
        logic add;
        logic mul;
    } ecghr_mean_ctl_t;

    // Status of the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } ecghr_div_stat_t;

endpackage

FILE: hdl/ecghr_mean.sv
// Window mean unit: one shared accumulator fed one tap per cycle while
// add is set, then a reciprocal multiply that floors the sum divided by
// the window length. Depends on ecghr_pkg.
module ecghr_mean (
    input  logic                                  aclk,
    input  ecghr_pkg::ecghr_mean_ctl_t            ctl,
    input  logic signed [ecghr_pkg::AMP_W-1:0]    tap,
    output logic signed [ecghr_pkg::AMP_W-1:0]    mean
);
    import ecghr_pkg::*;

    logic signed [SUM_W-1:0]  acc_reg;
    logic        [SUM_W-1:0]  biased;
    logic        [PROD_W-1:0] prod_reg;
    logic        [AMP_W-1:0]  quot;

    // Bias the sum so that the floor division works on unsigned values.
    assign biased = acc_reg + SUM_W'(MEAN_OFFSET);

    // Undo the bias: the biased quotient is the true one plus half range.
    assign quot = prod_reg[RECIP_SHIFT +: AMP_W];
    assign mean = {~quot[AMP_W-1], quot[AMP_W-2:0]};

    // Accumulate taps, then register the reciprocal product.
    always_ff @(posedge aclk) begin
        if (ctl.clr) begin
            acc_reg <= '0;
        end else if (ctl.add) begin
            acc_reg <= acc_reg + SUM_W'(tap);
        end
        if (ctl.mul) begin
            prod_reg <= PROD_W'(biased) * PROD_W'(RECIP_MUL);
        end
    end

endmodule

FILE: hdl/ecghr_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on ecghr_pkg.
module ecghr_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [ecghr_pkg::DIV_W-1:0]      dividend,
    input  logic [ecghr_pkg::DIV_W-1:0]      divisor,
    output ecghr_pkg::ecghr_div_stat_t       stat,
    output logic [ecghr_pkg::DIV_W-1:0]      quotient
);
    import ecghr_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     dvs_reg;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;

    // Shift in the next dividend bit and try a subtraction.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    // Control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
            cnt_reg <= DIV_CNT_W'(DIV_W - 1);
        end else if (busy_reg) begin
            rem_reg <= diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ~diff[DIV_W]};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

FILE: hdl/ecg_heart_rate_estimator_core.sv
// ECG heart rate estimator, top level: sequencer, record state and ports.
// Depends on ecghr_pkg, ecghr_mean, ecghr_div and the assertion macro header.
//
// Takes one ECG sample per request and accepts no new sample until it has
// finished with the current one. A sample whose five-sample centred mean is
// due is accepted, takes five accumulate steps through the shared adder,
// the reciprocal multiply and the peak check; an early sample of a record
// is accepted and at most peak checked. The sample marked last also pushes
// the pending raw samples, multiplies the peak count and runs the serial
// divider, unless the record duration is zero. One result per record is
// held in an output register; a new record can run while it waits, and
// only the next result waits for it to be taken.
`include "ecg_heart_rate_estimator_core_macros.svh"

module ecg_heart_rate_estimator_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Sample channel.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [31:0] sample_time, [47:32] sample_amplitude
    input  logic [ecghr_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                  s_tlast,
    // Result channel.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [15:0] peak_count, [47:16] record_duration, [63:48] heart_rate_bpm
    output logic [ecghr_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // Peak threshold write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ecghr_pkg::AMP_W-1:0]           cfg_data
);
    import ecghr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL,
        ST_PUSH,
        ST_RMUL,
        ST_RDIV,
        ST_RWAIT,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic signed [AMP_W-1:0] thresh_reg, thresh_next;
    logic [SEEN_W-1:0]       samples_seen_reg, samples_seen_next;
    logic [COUNT_W-1:0]      peaks_reg, peaks_next;
    logic [PUSH_CNT_W-1:0]   push_cnt_reg, push_cnt_next;
    logic                    last_reg, last_next;
    logic                    flushing_reg, flushing_next;
    logic                    use_mean_reg, use_mean_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]        flush_start_reg, flush_start_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    logic signed [AMP_W-1:0] window_reg [WINDOW_TAPS];
    logic signed [AMP_W-1:0] window_next [WINDOW_TAPS];
    logic signed [AMP_W-1:0] hist_reg [2];
    logic signed [AMP_W-1:0] hist_next [2];
    logic [TIME_W-1:0]       first_reg, first_next;
    logic [TIME_W-1:0]       latest_reg, latest_next;
    logic [SCALED_W-1:0]     scaled_reg, scaled_next;
    logic [TIME_W-1:0]       dur_reg, dur_next;
    logic [RATE_W-1:0]       rate_reg, rate_next;
    logic [COUNT_W-1:0]      m_peaks_reg, m_peaks_next;
    logic [TIME_W-1:0]       m_dur_reg, m_dur_next;
    logic [RATE_W-1:0]       m_rate_reg, m_rate_next;

    logic [TIME_W-1:0]       in_time;
    logic signed [AMP_W-1:0] in_amp;
    logic signed [AMP_W-1:0] rd_tap;
    logic signed [AMP_W-1:0] mean_val;
    logic signed [AMP_W-1:0] push_val;
    logic signed [AMP_W-1:0] mid;
    logic                    is_peak;
    logic [SEEN_W-1:0]       k;

    ecghr_mean_ctl_t         mean_ctl;
    ecghr_div_stat_t         div_stat;
    logic                    div_start;
    logic [DIV_W-1:0]        div_quo;

    assign in_time   = s_tdata[TIME_W-1:0];
    assign in_amp    = s_tdata[TIME_W +: AMP_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {m_rate_reg, m_dur_reg, m_peaks_reg};

    // Single read port on the raw window.
    assign rd_tap   = window_reg[rd_idx_reg];
    assign push_val = use_mean_reg ? mean_val : rd_tap;
    assign k        = samples_seen_reg;

    // A peak is strictly above the threshold and both its pushed neighbours.
    assign mid     = hist_reg[1];
    assign is_peak = (push_cnt_reg == PUSH_CNT_W'(2)) && (mid > thresh_reg) &&
                     (mid > hist_reg[0]) && (mid > push_val);

    ecghr_mean u_mean (
        .aclk (aclk),
        .ctl  (mean_ctl),
        .tap  (rd_tap),
        .mean (mean_val)
    );

    ecghr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (scaled_reg),
        .divisor  (dur_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // Sequencer and next-state logic.
    always_comb begin
        state_next        = state_reg;
        thresh_next       = thresh_reg;
        samples_seen_next = samples_seen_reg;
        peaks_next        = peaks_reg;
        push_cnt_next     = push_cnt_reg;
        last_next         = last_reg;
        flushing_next     = flushing_reg;
        use_mean_next     = use_mean_reg;
        rd_idx_next       = rd_idx_reg;
        flush_start_next  = flush_start_reg;
        m_tvalid_next     = m_tvalid_reg;
        window_next       = window_reg;
        hist_next         = hist_reg;
        first_next        = first_reg;
        latest_next       = latest_reg;
        scaled_next       = scaled_reg;
        dur_next          = dur_reg;
        rate_next         = rate_reg;
        m_peaks_next      = m_peaks_reg;
        m_dur_next        = m_dur_reg;
        m_rate_next       = m_rate_reg;
        mean_ctl          = '0;
        div_start         = 1'b0;

        // The user must write the threshold only while the block is idle; the block itself does not enforce it.
        if (cfg_valid) begin
            thresh_next = cfg_data;
        end

        // The held result leaves when the consumer takes it.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (k == '0) begin
                        first_next = in_time;
                    end
                    latest_next = in_time;
                    for (int i = 0; i < WINDOW_TAPS - 1; i++) begin
                        window_next[i] = window_reg[i + 1];
                    end
                    window_next[WINDOW_TAPS-1] = in_amp;
                    samples_seen_next = (k < SEEN_W'(WINDOW_TAPS - 1)) ?
                                        k + 1'b1 : SEEN_W'(WINDOW_TAPS);
                    last_next     = s_tlast;
                    flushing_next = 1'b0;
                    use_mean_next = 1'b0;

                    // Where the raw flush of a closing record begins.
                    if (k >= SEEN_W'(HALF_SPAN)) begin
                        flush_start_next = IDX_W'(WINDOW_TAPS - HALF_SPAN);
                    end else begin
                        flush_start_next = IDX_W'(SEEN_W'(WINDOW_TAPS - 1) - k);
                    end

                    // How many smoothed values this record has settled.
                    if (k >= SEEN_W'(HALF_SPAN + 2)) begin
                        push_cnt_next = PUSH_CNT_W'(2);
                    end else if (k >= SEEN_W'(HALF_SPAN)) begin
                        push_cnt_next = PUSH_CNT_W'(k - SEEN_W'(HALF_SPAN));
                    end else begin
                        push_cnt_next = '0;
                    end

                    if (k >= SEEN_W'(2 * HALF_SPAN)) begin
                        mean_ctl.clr  = 1'b1;
                        use_mean_next = 1'b1;
                        rd_idx_next   = IDX_W'(MEAN_START);
                        state_next    = ST_ACC;
                    end else if (k >= SEEN_W'(HALF_SPAN)) begin
                        rd_idx_next = IDX_W'(WINDOW_TAPS - 1 - HALF_SPAN);
                        state_next  = ST_PUSH;
                    end else if (s_tlast) begin
                        flushing_next = 1'b1;
                        rd_idx_next   = IDX_W'(SEEN_W'(WINDOW_TAPS - 1) - k);
                        state_next    = ST_PUSH;
                    end
                end
            end

            ST_ACC: begin
                mean_ctl.add = 1'b1;
                if (rd_idx_reg == IDX_W'(WINDOW_TAPS - 1)) begin
                    state_next = ST_MUL;
                end else begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end

            ST_MUL: begin
                mean_ctl.mul = 1'b1;
                state_next   = ST_PUSH;
            end

            ST_PUSH: begin
                // Settle one value, smoothed or raw, and judge the one before it.
                if (is_peak && peaks_reg != COUNT_MAX) begin
                    peaks_next = peaks_reg + 1'b1;
                end
                hist_next[0] = hist_reg[1];
                hist_next[1] = push_val;
                if (push_cnt_reg != PUSH_CNT_W'(2)) begin
                    push_cnt_next = push_cnt_reg + 1'b1;
                end
                use_mean_next = 1'b0;
                if (flushing_reg) begin
                    if (rd_idx_reg == IDX_W'(WINDOW_TAPS - 1)) begin
                        state_next = ST_RMUL;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end else if (last_reg) begin
                    flushing_next = 1'b1;
                    rd_idx_next   = flush_start_reg;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_RMUL: begin
                scaled_next = SCALED_W'(peaks_reg) * SCALED_W'(BPM_SCALE);
                dur_next    = latest_reg - first_reg;
                state_next  = ST_RDIV;
            end

            ST_RDIV: begin
                if (dur_reg == '0) begin
                    rate_next  = '0;
                    state_next = ST_OUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_RWAIT;
                end
            end

            ST_RWAIT: begin
                if (div_stat.done) begin
                    rate_next  = (div_quo[DIV_W-1:RATE_W] != '0) ?
                                 RATE_MAX : div_quo[RATE_W-1:0];
                    state_next = ST_OUT;
                end
            end

            ST_OUT: begin
                // Load the result once the output register is free, then
                // clear the record state.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next     = 1'b1;
                    m_peaks_next      = peaks_reg;
                    m_dur_next        = dur_reg;
                    m_rate_next       = rate_reg;
                    samples_seen_next = '0;
                    peaks_next        = '0;
                    first_next        = '0;
                    latest_next       = '0;
                    for (int i = 0; i < WINDOW_TAPS; i++) begin
                        window_next[i] = '0;
                    end
                    hist_next[0] = '0;
                    hist_next[1] = '0;
                    last_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, record registers and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            thresh_reg       <= PEAK_THRESH_RESET;
            samples_seen_reg <= '0;
            peaks_reg        <= '0;
            push_cnt_reg     <= '0;
            last_reg         <= 1'b0;
            flushing_reg     <= 1'b0;
            use_mean_reg     <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            thresh_reg       <= thresh_next;
            samples_seen_reg <= samples_seen_next;
            peaks_reg        <= peaks_next;
            push_cnt_reg     <= push_cnt_next;
            last_reg         <= last_next;
            flushing_reg     <= flushing_next;
            use_mean_reg     <= use_mean_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
        rd_idx_reg      <= rd_idx_next;
        flush_start_reg <= flush_start_next;
        window_reg      <= window_next;
        hist_reg        <= hist_next;
        first_reg       <= first_next;
        latest_reg      <= latest_next;
        scaled_reg      <= scaled_next;
        dur_reg         <= dur_next;
        rate_reg        <= rate_next;
        m_peaks_reg     <= m_peaks_next;
        m_dur_reg       <= m_dur_next;
        m_rate_reg      <= m_rate_next;
    end

    // Checks on the sequencer and record bookkeeping.
    `ECGHR_ASSERT_ALWAYS(a_seen_bounded,
        samples_seen_reg <= SEEN_W'(WINDOW_TAPS),
        "samples_seen beyond window")
    `ECGHR_ASSERT_SAME(a_div_done_in_wait,
        div_stat.done, state_reg == ST_RWAIT,
        "divider finished outside wait")
    `ECGHR_ASSERT_NEXT(a_clear_after_result,
        (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready),
        (samples_seen_reg == '0) && (peaks_reg == '0) && m_tvalid_reg,
        "record not cleared after result")

endmodule
